// ===== rtl/dllc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_pkg
// Shared types and constants of the linked-list DMA channel.
// ----------------------------------------------------------------------------
package dllc_pkg;

	localparam int COUNT_BITS = 12;
	localparam int ADDR_BITS  = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_READ_BYTE  = 2'd0;
	localparam logic [1:0] KIND_WRITE_BYTE = 2'd1;
	localparam logic [1:0] KIND_READ_DESC  = 2'd2;
	localparam logic [1:0] KIND_DONE       = 2'd3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEST   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINK   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT  = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_BYTE = 3'b010,
		PH_DESC = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [ADDR_BITS-1:0] address;
		logic [7:0]           write_data;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic one;
		logic two;
		res_t a;
		res_t b;
	} push_t;

endpackage

// ===== rtl/dllc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_if
// Handshake channels of the DMA channel: control items, requests, config.
// ----------------------------------------------------------------------------
interface dllc_ctrl_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] read_data;
	modport source (output valid, output opcode, output read_data, input ready);
	modport sink (input valid, input opcode, input read_data, output ready);
endinterface

interface dllc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  request_kind;
	logic [31:0] address;
	logic [7:0]  write_data;
	logic        last;
	modport source (output valid, output request_kind, output address,
		output write_data, output last, input ready);
	modport sink (input valid, input request_kind, input address,
		input write_data, input last, output ready);
endinterface

interface dllc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dllc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_core
// Input register, channel state and the logic that turns one item into its
// requests.
// ----------------------------------------------------------------------------
module dllc_core
	import dllc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dllc_ctrl_if.sink  ctrl,
	dllc_cfg_if.sink   cfg,
	input  logic       room,
	output push_t      push
);

	logic                  enable_q;
	logic [ADDR_BITS-1:0]  start_source_q, start_dest_q, start_link_q;
	logic [COUNT_BITS-1:0] start_count_q;

	logic [ADDR_BITS-1:0]  source_q, dest_q, link_q, base_q;
	logic [COUNT_BITS-1:0] total_q, index_q;
	phase_t                phase_q;
	logic [1:0]            word_q;

	logic                  valid_s1;
	logic                  opcode_s1;
	logic [31:0]           data_s1;

	logic                  process;
	logic                  take;

	logic [ADDR_BITS-1:0]  source_n, dest_n, link_n, base_n;
	logic [COUNT_BITS-1:0] total_n, index_n, idx_inc, begin_count;
	phase_t                phase_n;
	logic [1:0]            word_n, word_inc;
	logic                  do_begin;
	logic [ADDR_BITS-1:0]  begin_source;
	res_t                  begin_res;

	assign cfg.ready  = 1'b1;
	assign process    = valid_s1 && room;
	assign ctrl.ready = !valid_s1 || room;
	assign take       = ctrl.valid && ctrl.ready;
	assign idx_inc    = index_q + 1'b1;
	assign word_inc   = word_q + 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			start_source_q <= '0;
			start_dest_q   <= '0;
			start_link_q   <= '0;
			start_count_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE: enable_q       <= cfg.data[0];
				REG_SOURCE: start_source_q <= cfg.data;
				REG_DEST:   start_dest_q   <= cfg.data;
				REG_LINK:   start_link_q   <= cfg.data;
				REG_COUNT:  start_count_q  <= cfg.data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= ctrl.opcode;
			data_s1   <= ctrl.read_data;
		end
	end

	always_comb begin
		begin_res.kind       = KIND_READ_BYTE;
		begin_res.address    = begin_source;
		begin_res.write_data = 8'd0;
		begin_res.last       = 1'b1;
		if (!enable_q || begin_count == '0) begin
			begin_res.kind    = KIND_DONE;
			begin_res.address = '0;
		end
	end

	always_comb begin
		source_n     = source_q;
		dest_n       = dest_q;
		link_n       = link_q;
		base_n       = base_q;
		total_n      = total_q;
		index_n      = index_q;
		phase_n      = phase_q;
		word_n       = word_q;
		do_begin     = 1'b0;
		begin_count  = start_count_q;
		begin_source = source_q;
		push         = '0;
		if (opcode_s1 == OP_START) begin
			source_n     = start_source_q;
			dest_n       = start_dest_q;
			link_n       = start_link_q;
			word_n       = 2'd0;
			begin_source = start_source_q;
			do_begin     = 1'b1;
		end else begin
			case (phase_q)
				PH_BYTE: begin
					push.one          = 1'b1;
					push.two          = 1'b1;
					push.a.kind       = KIND_WRITE_BYTE;
					push.a.address    = dest_q + ADDR_BITS'(index_q);
					push.a.write_data = data_s1[7:0];
					push.a.last       = 1'b0;
					push.b.last       = 1'b1;
					index_n           = idx_inc;
					if (idx_inc < total_q) begin
						push.b.kind    = KIND_READ_BYTE;
						push.b.address = source_q + ADDR_BITS'(idx_inc);
					end else if (link_q != '0) begin
						base_n         = link_q;
						word_n         = 2'd0;
						phase_n        = PH_DESC;
						push.b.kind    = KIND_READ_DESC;
						push.b.address = link_q;
					end else begin
						phase_n     = PH_IDLE;
						push.b.kind = KIND_DONE;
					end
				end
				PH_DESC: begin
					case (word_q)
						2'd0: source_n = data_s1;
						2'd1: dest_n   = data_s1;
						2'd2: link_n   = data_s1;
						default: begin
						end
					endcase
					if (word_q == 2'd3) begin
						word_n      = 2'd0;
						begin_count = data_s1[COUNT_BITS-1:0];
						do_begin    = 1'b1;
					end else begin
						word_n         = word_inc;
						push.one       = 1'b1;
						push.a.kind    = KIND_READ_DESC;
						push.a.address = base_q + {{(ADDR_BITS-4){1'b0}}, word_inc, 2'b00};
						push.a.last    = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (do_begin) begin
			push.one = 1'b1;
			push.a   = begin_res;
			if (!enable_q || begin_count == '0) begin
				phase_n = PH_IDLE;
			end else begin
				total_n = begin_count;
				index_n = '0;
				phase_n = PH_BYTE;
			end
		end
		if (!process) begin
			push.one = 1'b0;
			push.two = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
			dest_q   <= '0;
			link_q   <= '0;
			base_q   <= '0;
			total_q  <= '0;
			index_q  <= '0;
			phase_q  <= PH_IDLE;
			word_q   <= 2'd0;
		end else if (process) begin
			source_q <= source_n;
			dest_q   <= dest_n;
			link_q   <= link_n;
			base_q   <= base_n;
			total_q  <= total_n;
			index_q  <= index_n;
			phase_q  <= phase_n;
			word_q   <= word_n;
		end
	end

endmodule

// ===== rtl/dllc_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_outq
// Small result queue that takes up to two requests a cycle and hands out one.
// ----------------------------------------------------------------------------
module dllc_outq
	import dllc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	dllc_req_if.source  req
);

	res_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] head_q;
	logic [QPTR_BITS:0]   count_q;
	logic [QPTR_BITS:0]   kept;
	logic [QPTR_BITS-1:0] tail0, tail1;
	logic                 pop;
	res_t                 head_res;

	assign head_res         = entry_q[head_q];
	assign req.valid        = count_q != '0;
	assign req.request_kind = head_res.kind;
	assign req.address      = head_res.address;
	assign req.write_data   = head_res.write_data;
	assign req.last         = head_res.last;

	assign pop   = req.valid && req.ready;
	assign kept  = count_q - {{QPTR_BITS{1'b0}}, pop};
	assign room  = kept <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2);
	assign tail0 = head_q + count_q[QPTR_BITS-1:0];
	assign tail1 = tail0 + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= kept + {{QPTR_BITS{1'b0}}, push.one} + {{QPTR_BITS{1'b0}}, push.two};
		end
	end

	always_ff @(posedge clk) begin
		if (push.one) begin
			entry_q[tail0] <= push.a;
		end
		if (push.two) begin
			entry_q[tail1] <= push.b;
		end
	end

endmodule

// ===== rtl/dma_linked_list_channel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_linked_list_channel_top
// Single DMA channel that walks a chain of linked descriptors, byte by byte.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload
//  cfg      sink    index, data (register writes, always ready)
//  ctrl     sink    opcode, read_data (start or returned memory data)
//  req      source  request_kind, address, write_data, last
//
//  An item enters a register, is processed once the queue has room, and its
//  one or two requests land in a four-entry queue that drives req.
//  One item per cycle is accepted while the queue keeps room for two requests,
//  so a stream of byte items, each giving two requests, is paced by req.
//  Reset clears all channel state to idle; no clearing pass is needed.
//  A stalled req holds its request and fills the queue, which then holds ctrl.
// ----------------------------------------------------------------------------
module dma_linked_list_channel_top
	import dllc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dllc_cfg_if.sink    cfg,
	dllc_ctrl_if.sink   ctrl,
	dllc_req_if.source  req
);

	logic  room;
	push_t push;

	dllc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	dllc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.req    (req)
	);

endmodule

// ===== tb/dllc_request_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_request_checker
// Watches the register, control and request channels of the DMA channel. It
// keeps its own copy of the registers and channel state, works out the
// requests that each accepted control item must cause, and compares every
// accepted request field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dllc_request_checker
	import dllc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dllc_cfg_if  cfg,
	dllc_ctrl_if ctrl,
	dllc_req_if  req,
	input  logic run_over,
	output int   pending,
	output int   mismatches
);

	localparam int PRINT_LIMIT = 40;

	logic                  reg_enable;
	logic [ADDR_BITS-1:0]  reg_source;
	logic [ADDR_BITS-1:0]  reg_dest;
	logic [ADDR_BITS-1:0]  reg_link;
	logic [COUNT_BITS-1:0] reg_count;

	logic [ADDR_BITS-1:0]  src_ptr;
	logic [ADDR_BITS-1:0]  dst_ptr;
	logic [ADDR_BITS-1:0]  link_ptr;
	logic [ADDR_BITS-1:0]  desc_base;
	logic [COUNT_BITS-1:0] total_bytes;
	logic [COUNT_BITS-1:0] byte_pos;
	logic [1:0]            word_pos;
	phase_t                phase;
	res_t                  expected_requests[$];
	bit                    leftover_checked;

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s", $time, what);
		mismatches = mismatches + 1;
	endtask

	task automatic expect_request(input logic [1:0] kind, input logic [ADDR_BITS-1:0] addr,
			input logic [7:0] data, input logic last);
		res_t r;
		r.kind = kind;
		r.address = addr;
		r.write_data = data;
		r.last = last;
		expected_requests.push_back(r);
	endtask

	task automatic begin_transfer(input logic [COUNT_BITS-1:0] n);
		if (!reg_enable || n == '0) begin
			phase = PH_IDLE;
			expect_request(KIND_DONE, '0, '0, 1'b1);
		end else begin
			total_bytes = n;
			byte_pos = '0;
			phase = PH_BYTE;
			expect_request(KIND_READ_BYTE, src_ptr, '0, 1'b1);
		end
	endtask

	task automatic apply_config(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		case (idx)
		REG_ENABLE: reg_enable = data[0];
		REG_SOURCE: reg_source = data;
		REG_DEST: reg_dest = data;
		REG_LINK: reg_link = data;
		REG_COUNT: reg_count = data[COUNT_BITS-1:0];
		default: ;
		endcase
	endtask

	task automatic predict_item(input logic op, input logic [31:0] data);
		if (op == OP_START) begin
			src_ptr = reg_source;
			dst_ptr = reg_dest;
			link_ptr = reg_link;
			word_pos = '0;
			begin_transfer(reg_count);
		end else if (phase == PH_BYTE) begin
			expect_request(KIND_WRITE_BYTE, dst_ptr + ADDR_BITS'(byte_pos), data[7:0], 1'b0);
			byte_pos = byte_pos + 1'b1;
			if (byte_pos < total_bytes) begin
				expect_request(KIND_READ_BYTE, src_ptr + ADDR_BITS'(byte_pos), '0, 1'b1);
			end else if (link_ptr != '0) begin
				desc_base = link_ptr;
				word_pos = '0;
				phase = PH_DESC;
				expect_request(KIND_READ_DESC, desc_base, '0, 1'b1);
			end else begin
				phase = PH_IDLE;
				expect_request(KIND_DONE, '0, '0, 1'b1);
			end
		end else if (phase == PH_DESC) begin
			// Descriptor words arrive as source, destination, link, control.
			case (word_pos)
			2'd0: src_ptr = data;
			2'd1: dst_ptr = data;
			2'd2: link_ptr = data;
			default: ;
			endcase
			if (word_pos == 2'd3) begin
				word_pos = '0;
				begin_transfer(data[COUNT_BITS-1:0]);
			end else begin
				word_pos = word_pos + 1'b1;
				expect_request(KIND_READ_DESC, desc_base + ADDR_BITS'({word_pos, 2'b00}),
					'0, 1'b1);
			end
		end
	endtask

	task automatic check_request();
		res_t want;
		if (expected_requests.size() == 0) begin
			flag_mismatch($sformatf("unexpected request kind %0d address %h data %h last %b",
				req.request_kind, req.address, req.write_data, req.last));
			return;
		end
		want = expected_requests.pop_front();
		if (req.request_kind !== want.kind)
			flag_mismatch($sformatf("request_kind %0d, expected %0d",
				req.request_kind, want.kind));
		if (req.address !== want.address)
			flag_mismatch($sformatf("address %h, expected %h", req.address, want.address));
		if (req.write_data !== want.write_data)
			flag_mismatch($sformatf("write_data %h, expected %h",
				req.write_data, want.write_data));
		if (req.last !== want.last)
			flag_mismatch($sformatf("last %b, expected %b", req.last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_enable = 1'b0;
			reg_source = '0;
			reg_dest = '0;
			reg_link = '0;
			reg_count = '0;
			src_ptr = '0;
			dst_ptr = '0;
			link_ptr = '0;
			desc_base = '0;
			total_bytes = '0;
			byte_pos = '0;
			word_pos = '0;
			phase = PH_IDLE;
			expected_requests.delete();
			leftover_checked = 1'b0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				apply_config(cfg.index, cfg.data);
			if (ctrl.valid && ctrl.ready)
				predict_item(ctrl.opcode, ctrl.read_data);
			if (req.valid && req.ready)
				check_request();
			if (run_over && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_requests.size() != 0)
					flag_mismatch($sformatf("%0d expected requests never arrived",
						expected_requests.size()));
			end
			pending <= expected_requests.size();
		end
	end

endmodule

// ===== tb/tb_dma_linked_list_channel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_linked_list_channel_top
// Drives register writes and control items into the DMA channel: a short
// directed run over the corner cases, then random descriptor chains fed with
// random memory data, with random gaps on both handshake sides. A separate
// checker predicts and compares the requests; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dma_linked_list_channel_top;
	import dllc_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 20;
	localparam int ITEM_TARGET   = 1650;
	localparam logic [4:0] ALL_REGS = 5'b11111;

	logic clk;
	logic arst_n;
	logic run_over;
	int   pending;
	int   mismatches;
	int   idle_cycles;
	int   items_sent;
	bit   source_calm;
	bit   sink_calm;

	logic                  plan_enable;
	logic [31:0]           plan_link;
	logic [COUNT_BITS-1:0] plan_count;

	dllc_cfg_if  cfg ();
	dllc_ctrl_if ctrl ();
	dllc_req_if  req ();

	dma_linked_list_channel_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.req    (req)
	);

	dllc_request_checker request_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctrl       (ctrl),
		.req        (req),
		.run_over   (run_over),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((ctrl.valid && ctrl.ready) || (req.valid && req.ready) ||
					(cfg.valid && cfg.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_dma_linked_list_channel_top failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : result_sink
		int stall;
		req.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				req.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			req.ready <= 1'b1;
			do @(posedge clk); while (!req.valid);
			if ($urandom_range(0, 47) == 0)
				sink_calm = !sink_calm;
		end
	end

	function automatic logic [31:0] pick_address(input bit nonzero);
		logic [31:0] a;
		case ($urandom_range(0, 7))
		0: a = 32'hFFFF_FFFF - $urandom_range(0, 15);
		1: a = $urandom_range(0, 255);
		default: a = $urandom;
		endcase
		if (nonzero && a == '0)
			a = 32'h4;
		return a;
	endfunction

	function automatic logic [COUNT_BITS-1:0] pick_count(input bit big_ok);
		if (big_ok && $urandom_range(0, 7) == 0)
			return COUNT_BITS'($urandom);
		case ($urandom_range(0, 19))
		0, 1: return '0;
		2: return COUNT_BITS'($urandom_range(7, 40));
		default: return COUNT_BITS'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [31:0] data, input bit counted);
		int gap;
		gap = source_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			ctrl.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ctrl.valid <= 1'b1;
		ctrl.opcode <= op;
		ctrl.read_data <= data;
		do @(posedge clk); while (!ctrl.ready);
		if (counted)
			items_sent++;
		if ($urandom_range(0, 47) == 0)
			source_calm = !source_calm;
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic configure(input logic [4:0] mask, input logic en, input logic [31:0] src,
			input logic [31:0] dst, input logic [31:0] link, input logic [COUNT_BITS-1:0] n);
		if (mask[REG_ENABLE]) begin
			write_register(REG_ENABLE, {31'($urandom), en});
			plan_enable = en;
		end
		if (mask[REG_SOURCE])
			write_register(REG_SOURCE, src);
		if (mask[REG_DEST])
			write_register(REG_DEST, dst);
		if (mask[REG_LINK]) begin
			write_register(REG_LINK, link);
			plan_link = link;
		end
		if (mask[REG_COUNT]) begin
			write_register(REG_COUNT, {20'($urandom), n});
			plan_count = n;
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic settle();
		ctrl.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Feeds one chain as memory would: the bytes of each transfer, then the
	// four descriptor words where a link is set. Running out of budget leaves
	// the chain unfinished, so the next start abandons it.
	task automatic run_chain(input int budget);
		logic [COUNT_BITS-1:0] n;
		logic [31:0]           link;
		logic [31:0]           words[4];
		int                    used;
		used = 0;
		n = plan_count;
		link = plan_link;
		send_item(OP_START, $urandom, 1'b1);
		if (!plan_enable)
			return;
		while (n != 0 && used < budget) begin
			if (n > 64 && budget - used > 24)
				budget = used + $urandom_range(1, 24);
			for (int i = 0; i < n && used < budget; i++) begin
				send_item(OP_DATA, $urandom, 1'b1);
				used++;
			end
			if (link == '0)
				break;
			words[0] = pick_address(1'b0);
			words[1] = pick_address(1'b0);
			words[2] = ($urandom_range(0, 2) == 0) ? '0 : pick_address(1'b1);
			words[3] = {20'($urandom), pick_count(1'b1)};
			for (int i = 0; i < 4 && used < budget; i++) begin
				send_item(OP_DATA, words[i], 1'b1);
				used++;
			end
			n = words[3][COUNT_BITS-1:0];
			link = words[2];
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		run_over <= 1'b0;
		ctrl.valid <= 1'b0;
		ctrl.opcode <= OP_START;
		ctrl.read_data <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_ENABLE;
		cfg.data <= '0;
		plan_enable = 1'b0;
		plan_link = '0;
		plan_count = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset, then read data while idle.
		send_item(OP_START, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'hFFFF_FFFF, 1'b0);
		settle();

		// Byte and descriptor addresses wrap past the top of memory.
		configure(ALL_REGS, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 12'd3);
		send_item(OP_START, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_DATA, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_DATA, 32'h5A5A_A5A5, 1'b1);
		send_item(OP_DATA, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_DATA, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'hFFFF_F001, 1'b1);
		send_item(OP_DATA, 32'h1234_5680, 1'b1);
		settle();

		// A zero count ends the chain even with a link set.
		configure(ALL_REGS, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0010, 12'd0);
		send_item(OP_START, 32'h0000_0000, 1'b1);
		settle();

		// Full byte count, abandoned by a second start.
		configure(ALL_REGS, 1'b1, 32'h0000_0000, 32'h0000_0100, 32'h0000_0000, 12'hFFF);
		send_item(OP_START, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'h0000_00FF, 1'b1);
		send_item(OP_DATA, 32'hFFFF_FF00, 1'b1);
		send_item(OP_START, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_DATA, 32'h0000_0080, 1'b1);
		settle();

		// A descriptor whose control holds a zero count.
		configure(ALL_REGS, 1'b1, 32'h0000_0040, 32'h0000_0080, 32'h0000_0200, 12'd1);
		send_item(OP_START, 32'h0000_0000, 1'b1);
		send_item(OP_DATA, 32'h0000_0011, 1'b1);
		send_item(OP_DATA, 32'h0000_1000, 1'b1);
		send_item(OP_DATA, 32'h0000_2000, 1'b1);
		send_item(OP_DATA, 32'h0000_0300, 1'b1);
		send_item(OP_DATA, 32'hFFFF_F000, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			settle();
			configure(5'($urandom_range(1, 31)), $urandom_range(0, 5) != 0,
				pick_address(1'b0), pick_address(1'b0),
				($urandom_range(0, 2) == 0) ? 32'h0 : pick_address(1'b1),
				pick_count($urandom_range(0, 9) == 0));
			repeat ($urandom_range(1, 4)) begin
				run_chain(($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 200);
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
					send_item(OP_DATA, $urandom, 1'b0);
			end
		end

		settle();
		repeat (END_CYCLES) @(posedge clk);
		run_over <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatches == 0)
			$display("tb_dma_linked_list_channel_top passed");
		else
			$display("tb_dma_linked_list_channel_top failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dllc_pkg.sv
rtl/dllc_if.sv
rtl/dllc_core.sv
rtl/dllc_outq.sv
rtl/dma_linked_list_channel_top.sv
tb/dllc_request_checker.sv
tb/tb_dma_linked_list_channel_top.sv
